// ----- rtl/rcrd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the channel record decoder: record types carried along the digit chain
// and decode constants. No dependencies.
package rcrd_pkg;

    localparam int NUM_DIGITS  = 8;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int FREQ_ACC_W  = 28;
    localparam int TONE_ACC_W  = 15;
    localparam int HZ_W        = 31;
    localparam int CTCSS_W     = 13;
    localparam int DCS_W       = 14;
    localparam int OPT_W       = 5;

    localparam logic [BCD_W-1:0]      FREQ_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [15:0]           TONE_ALL_ONES = 16'hFFFF;
    localparam logic [TONE_ACC_W-1:0] CTCSS_LIMIT   = 15'd8000;
    localparam logic [TONE_ACC_W-1:0] DCS_INV_BASE  = 15'd12000;

    // option bit positions (all active low)
    localparam int OPT_NO_BUSY_LOCK = 0;
    localparam int OPT_NO_SCRAMBLE  = 1;
    localparam int OPT_NARROW       = 2;
    localparam int OPT_HIGH_POWER   = 3;
    localparam int OPT_NO_SCAN      = 4;

    typedef struct packed {
        logic [BCD_W-1:0]      rx_bcd;
        logic [BCD_W-1:0]      tx_bcd;
        logic [BCD_W-1:0]      rxt_bcd;
        logic [BCD_W-1:0]      txt_bcd;
        logic [FREQ_ACC_W-1:0] rx_acc;
        logic [FREQ_ACC_W-1:0] tx_acc;
        logic [TONE_ACC_W-1:0] rxt_acc;
        logic [TONE_ACC_W-1:0] txt_acc;
        logic                  chan_off;
        logic                  rxt_none;
        logic                  txt_none;
        logic [OPT_W-1:0]      opt;
    } rec_t;

endpackage

// ----- rtl/rcrd_digit_cell.sv -----
`timescale 1ns / 1ps
// One digit cell of the chain: folds the top BCD digit of each field into its accumulator.
// Depends on rcrd_pkg.
module rcrd_digit_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  rcrd_pkg::rec_t up_rec,
    output logic          dn_valid,
    input  logic          dn_ready,
    output rcrd_pkg::rec_t dn_rec
);

    logic           valid_reg;
    logic           valid_next;
    rcrd_pkg::rec_t rec_reg;
    rcrd_pkg::rec_t rec_next;

    function automatic logic [rcrd_pkg::FREQ_ACC_W-1:0] freq_step(
        input logic [rcrd_pkg::FREQ_ACC_W-1:0] acc,
        input logic [3:0]                      nib
    );
        freq_step = {acc[rcrd_pkg::FREQ_ACC_W-4:0], 3'b000}
                  + {acc[rcrd_pkg::FREQ_ACC_W-2:0], 1'b0}
                  + rcrd_pkg::FREQ_ACC_W'(nib);
    endfunction

    function automatic logic [rcrd_pkg::TONE_ACC_W-1:0] tone_step(
        input logic [rcrd_pkg::TONE_ACC_W-1:0] acc,
        input logic [3:0]                      nib
    );
        tone_step = {acc[rcrd_pkg::TONE_ACC_W-4:0], 3'b000}
                  + {acc[rcrd_pkg::TONE_ACC_W-2:0], 1'b0}
                  + rcrd_pkg::TONE_ACC_W'(nib);
    endfunction

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        rec_next         = up_rec;
        rec_next.rx_acc  = freq_step(up_rec.rx_acc, up_rec.rx_bcd[rcrd_pkg::BCD_W-1 -: 4]);
        rec_next.tx_acc  = freq_step(up_rec.tx_acc, up_rec.tx_bcd[rcrd_pkg::BCD_W-1 -: 4]);
        rec_next.rxt_acc = tone_step(up_rec.rxt_acc, up_rec.rxt_bcd[rcrd_pkg::BCD_W-1 -: 4]);
        rec_next.txt_acc = tone_step(up_rec.txt_acc, up_rec.txt_bcd[rcrd_pkg::BCD_W-1 -: 4]);
        rec_next.rx_bcd  = {up_rec.rx_bcd[rcrd_pkg::BCD_W-5:0], 4'h0};
        rec_next.tx_bcd  = {up_rec.tx_bcd[rcrd_pkg::BCD_W-5:0], 4'h0};
        rec_next.rxt_bcd = {up_rec.rxt_bcd[rcrd_pkg::BCD_W-5:0], 4'h0};
        rec_next.txt_bcd = {up_rec.txt_bcd[rcrd_pkg::BCD_W-5:0], 4'h0};
        valid_next       = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rec_reg <= rec_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rec   = rec_reg;

endmodule

// ----- rtl/rcrd_decode.sv -----
`timescale 1ns / 1ps
// Output stage: scales frequencies to Hz, classifies squelch codes, maps option flags
// and holds the result register. Depends on rcrd_pkg.
module rcrd_decode
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             up_valid,
    output logic                             up_ready,
    input  rcrd_pkg::rec_t                   up_rec,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             channel_on,
    output logic [rcrd_pkg::HZ_W-1:0]        rx_hz,
    output logic [rcrd_pkg::HZ_W-1:0]        tx_hz,
    output logic [rcrd_pkg::CTCSS_W-1:0]     rx_ctcss,
    output logic [rcrd_pkg::CTCSS_W-1:0]     tx_ctcss,
    output logic signed [rcrd_pkg::DCS_W-1:0] rx_dcs,
    output logic signed [rcrd_pkg::DCS_W-1:0] tx_dcs,
    output logic                             low_power,
    output logic                             wide_band,
    output logic                             scan_on,
    output logic                             busy_lockout,
    output logic                             scramble_on
);

    logic                               valid_reg;
    logic                               valid_next;
    logic                               on_reg;
    logic [rcrd_pkg::HZ_W-1:0]          rx_hz_reg, rx_hz_next;
    logic [rcrd_pkg::HZ_W-1:0]          tx_hz_reg, tx_hz_next;
    logic [rcrd_pkg::CTCSS_W-1:0]       rx_ctcss_reg, rx_ctcss_next;
    logic [rcrd_pkg::CTCSS_W-1:0]       tx_ctcss_reg, tx_ctcss_next;
    logic [rcrd_pkg::DCS_W-1:0]         rx_dcs_reg, rx_dcs_next;
    logic [rcrd_pkg::DCS_W-1:0]         tx_dcs_reg, tx_dcs_next;
    logic [rcrd_pkg::OPT_W-1:0]         flags_reg, flags_next;

    function automatic logic [rcrd_pkg::HZ_W-1:0] times_ten(
        input logic [rcrd_pkg::FREQ_ACC_W-1:0] acc
    );
        times_ten = {acc, 3'b000} + rcrd_pkg::HZ_W'({acc, 1'b0});
    endfunction

    function automatic logic [rcrd_pkg::CTCSS_W+rcrd_pkg::DCS_W-1:0] squelch(
        input logic                          none,
        input logic [rcrd_pkg::TONE_ACC_W-1:0] idx
    );
        logic [rcrd_pkg::CTCSS_W-1:0]    ctcss;
        logic [rcrd_pkg::TONE_ACC_W-1:0] diff;
        logic [rcrd_pkg::DCS_W-1:0]      dcs;
        ctcss = '0;
        dcs   = '0;
        if (none)
        begin
            ctcss = '0;
        end
        else if (idx < rcrd_pkg::CTCSS_LIMIT)
        begin
            ctcss = idx[rcrd_pkg::CTCSS_W-1:0];
        end
        else if (idx < rcrd_pkg::DCS_INV_BASE)
        begin
            diff = idx - rcrd_pkg::CTCSS_LIMIT;
            dcs  = diff[rcrd_pkg::DCS_W-1:0];
        end
        else
        begin
            // inverted code, negated modulo the field width
            diff = rcrd_pkg::DCS_INV_BASE - idx;
            dcs  = diff[rcrd_pkg::DCS_W-1:0];
        end
        squelch = {ctcss, dcs};
    endfunction

    assign up_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        rx_hz_next = times_ten(up_rec.rx_acc);
        tx_hz_next = times_ten(up_rec.tx_acc);
        {rx_ctcss_next, rx_dcs_next} = squelch(up_rec.rxt_none, up_rec.rxt_acc);
        {tx_ctcss_next, tx_dcs_next} = squelch(up_rec.txt_none, up_rec.txt_acc);
        flags_next = ~up_rec.opt;
        if (up_rec.chan_off)
        begin
            rx_hz_next    = '0;
            tx_hz_next    = '0;
            rx_ctcss_next = '0;
            tx_ctcss_next = '0;
            rx_dcs_next   = '0;
            tx_dcs_next   = '0;
            flags_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            on_reg       <= !up_rec.chan_off;
            rx_hz_reg    <= rx_hz_next;
            tx_hz_reg    <= tx_hz_next;
            rx_ctcss_reg <= rx_ctcss_next;
            tx_ctcss_reg <= tx_ctcss_next;
            rx_dcs_reg   <= rx_dcs_next;
            tx_dcs_reg   <= tx_dcs_next;
            flags_reg    <= flags_next;
        end
    end

    assign out_valid    = valid_reg;
    assign channel_on   = on_reg;
    assign rx_hz        = rx_hz_reg;
    assign tx_hz        = tx_hz_reg;
    assign rx_ctcss     = rx_ctcss_reg;
    assign tx_ctcss     = tx_ctcss_reg;
    assign rx_dcs       = rx_dcs_reg;
    assign tx_dcs       = tx_dcs_reg;
    assign low_power    = flags_reg[rcrd_pkg::OPT_HIGH_POWER];
    assign wide_band    = flags_reg[rcrd_pkg::OPT_NARROW];
    assign scan_on      = flags_reg[rcrd_pkg::OPT_NO_SCAN];
    assign busy_lockout = flags_reg[rcrd_pkg::OPT_NO_BUSY_LOCK];
    assign scramble_on  = flags_reg[rcrd_pkg::OPT_NO_SCRAMBLE];

endmodule

// ----- rtl/radio_channel_record_decoder_core.sv -----
`timescale 1ns / 1ps
// Top level of the channel record decoder: eight digit cells in a row and the output stage.
// Depends on rcrd_pkg, rcrd_digit_cell and rcrd_decode.
//
// Decodes one channel record per item with no state between items. An item is taken every
// cycle while the output keeps flowing; each item passes through eight BCD digit cells, one
// digit each, then the output register. Each stage has its own valid bit, so empty stages
// fill while the output is stalled and in_stall only rises once every stage holds an item.
module radio_channel_record_decoder_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [31:0]                       rx_freq_bcd,
    input  logic [31:0]                       tx_freq_bcd,
    input  logic [15:0]                       rx_tone_code,
    input  logic [15:0]                       tx_tone_code,
    input  logic [4:0]                        option_bits,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              channel_on,
    output logic [30:0]                       rx_hz,
    output logic [30:0]                       tx_hz,
    output logic [12:0]                       rx_ctcss,
    output logic [12:0]                       tx_ctcss,
    output logic signed [13:0]                rx_dcs,
    output logic signed [13:0]                tx_dcs,
    output logic                              low_power,
    output logic                              wide_band,
    output logic                              scan_on,
    output logic                              busy_lockout,
    output logic                              scramble_on
);

    logic           stage_valid [rcrd_pkg::NUM_DIGITS+1];
    logic           stage_ready [rcrd_pkg::NUM_DIGITS+1];
    rcrd_pkg::rec_t stage_rec   [rcrd_pkg::NUM_DIGITS+1];
    rcrd_pkg::rec_t in_rec;

    always_comb
    begin
        in_rec          = '0;
        in_rec.rx_bcd   = rx_freq_bcd;
        in_rec.tx_bcd   = tx_freq_bcd;
        // tone codes sit in the low digits so the leading cells fold in zeros
        in_rec.rxt_bcd  = {16'h0000, rx_tone_code};
        in_rec.txt_bcd  = {16'h0000, tx_tone_code};
        in_rec.chan_off = (rx_freq_bcd == '0) || (rx_freq_bcd == rcrd_pkg::FREQ_ALL_ONES);
        in_rec.rxt_none = (rx_tone_code == '0) || (rx_tone_code == rcrd_pkg::TONE_ALL_ONES);
        in_rec.txt_none = (tx_tone_code == '0) || (tx_tone_code == rcrd_pkg::TONE_ALL_ONES);
        in_rec.opt      = option_bits;
    end

    assign stage_rec[0]   = in_rec;
    assign stage_valid[0] = in_valid;
    assign in_stall       = !stage_ready[0];

    for (genvar i = 0; i < rcrd_pkg::NUM_DIGITS; i++)
    begin : g_cell
        rcrd_digit_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[i]),
            .up_ready (stage_ready[i]),
            .up_rec   (stage_rec[i]),
            .dn_valid (stage_valid[i+1]),
            .dn_ready (stage_ready[i+1]),
            .dn_rec   (stage_rec[i+1])
        );
    end

    rcrd_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (stage_valid[rcrd_pkg::NUM_DIGITS]),
        .up_ready     (stage_ready[rcrd_pkg::NUM_DIGITS]),
        .up_rec       (stage_rec[rcrd_pkg::NUM_DIGITS]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .channel_on   (channel_on),
        .rx_hz        (rx_hz),
        .tx_hz        (tx_hz),
        .rx_ctcss     (rx_ctcss),
        .tx_ctcss     (tx_ctcss),
        .rx_dcs       (rx_dcs),
        .tx_dcs       (tx_dcs),
        .low_power    (low_power),
        .wide_band    (wide_band),
        .scan_on      (scan_on),
        .busy_lockout (busy_lockout),
        .scramble_on  (scramble_on)
    );

endmodule

// ----- rtl/rcrd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the channel record decoder, bound to the top level.
// Depends on radio_channel_record_decoder_core for the bind target only.
module rcrd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               channel_on,
    input logic [30:0]        rx_hz,
    input logic [30:0]        tx_hz,
    input logic [12:0]        rx_ctcss,
    input logic [12:0]        tx_ctcss,
    input logic signed [13:0] rx_dcs,
    input logic signed [13:0] tx_dcs,
    input logic               low_power,
    input logic               wide_band,
    input logic               scan_on,
    input logic               busy_lockout,
    input logic               scramble_on
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rx_hz) && $stable(rx_dcs)
                                             && $stable(channel_on))
        else $error("stalled output item changed");

    // with the output empty every stage can take an item
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output empty");

    a_off_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !channel_on |-> rx_hz == 31'd0 && tx_hz == 31'd0
            && rx_ctcss == 13'd0 && tx_ctcss == 13'd0 && rx_dcs == 14'sd0 && tx_dcs == 14'sd0
            && !low_power && !wide_band && !scan_on && !busy_lockout && !scramble_on)
        else $error("channel off item carries nonzero fields");

    a_tone_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rx_ctcss == 13'd0 || rx_dcs == 14'sd0)
                   && (tx_ctcss == 13'd0 || tx_dcs == 14'sd0)
                   && rx_ctcss < 13'd8000 && tx_ctcss < 13'd8000)
        else $error("tone fields inconsistent");

endmodule

bind radio_channel_record_decoder_core rcrd_checker u_rcrd_checker (.*);

// ----- bench/radio_channel_record_decoder_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for radio_channel_record_decoder_core: a directed table, then random
// records, checked against a built-in decode of each record. Depends on rcrd_pkg and the RTL.
module radio_channel_record_decoder_core_test;

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] tx;
        logic [15:0] rxt;
        logic [15:0] txt;
        logic [4:0]  opt;
    } chan_record_t;

    typedef struct packed {
        logic        chan_on;
        logic [30:0] rx_hz;
        logic [30:0] tx_hz;
        logic [12:0] rx_ctcss;
        logic [12:0] tx_ctcss;
        logic [13:0] rx_dcs;
        logic [13:0] tx_dcs;
        logic        low_power;
        logic        wide_band;
        logic        scan_on;
        logic        busy_lockout;
        logic        scramble_on;
    } chan_result_t;

    typedef struct packed {
        logic [12:0] ctcss;
        logic [13:0] dcs;
    } tone_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] rx_freq_bcd = '0;
    logic [31:0] tx_freq_bcd = '0;
    logic [15:0] rx_tone_code = '0;
    logic [15:0] tx_tone_code = '0;
    logic [4:0]  option_bits = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        channel_on;
    logic [30:0] rx_hz;
    logic [30:0] tx_hz;
    logic [12:0] rx_ctcss;
    logic [12:0] tx_ctcss;
    logic signed [13:0] rx_dcs;
    logic signed [13:0] tx_dcs;
    logic        low_power;
    logic        wide_band;
    logic        scan_on;
    logic        busy_lockout;
    logic        scramble_on;

    chan_result_t expected_decodes[$];
    chan_record_t dir_records[$];
    bit           dir_typed[$];
    chan_result_t dir_results[$];

    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int mismatch_count = 0;
    int decodes_checked = 0;
    int records_sent = 0;
    int off_records = 0;
    int inverted_codes = 0;

    radio_channel_record_decoder_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_freq_bcd  (rx_freq_bcd),
        .tx_freq_bcd  (tx_freq_bcd),
        .rx_tone_code (rx_tone_code),
        .tx_tone_code (tx_tone_code),
        .option_bits  (option_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .channel_on   (channel_on),
        .rx_hz        (rx_hz),
        .tx_hz        (tx_hz),
        .rx_ctcss     (rx_ctcss),
        .tx_ctcss     (tx_ctcss),
        .rx_dcs       (rx_dcs),
        .tx_dcs       (tx_dcs),
        .low_power    (low_power),
        .wide_band    (wide_band),
        .scan_on      (scan_on),
        .busy_lockout (busy_lockout),
        .scramble_on  (scramble_on)
    );

    always #2 clk = ~clk;

    // digits above 9 keep their nibble value
    function automatic int unsigned bcd_weight(input logic [31:0] v, input int digits);
        int unsigned acc;
        acc = 0;
        for (int k = digits - 1; k >= 0; k--)
            acc = acc * 10 + v[4*k +: 4];
        return acc;
    endfunction

    function automatic tone_t decode_tone(input logic [15:0] code);
        tone_t t;
        int    idx;
        t = '0;
        if (code == 16'h0000 || code == rcrd_pkg::TONE_ALL_ONES)
            return t;
        idx = int'(bcd_weight({16'h0000, code}, 4));
        if (idx < int'(rcrd_pkg::CTCSS_LIMIT))
            t.ctcss = 13'(idx);
        else if (idx < int'(rcrd_pkg::DCS_INV_BASE))
            t.dcs = 14'(idx - int'(rcrd_pkg::CTCSS_LIMIT));
        else
            t.dcs = 14'(int'(rcrd_pkg::DCS_INV_BASE) - idx);
        return t;
    endfunction

    function automatic chan_result_t decode_record(input chan_record_t r);
        chan_result_t res;
        tone_t        rt;
        tone_t        tt;
        res = '0;
        if (r.rx == 32'h0 || r.rx == rcrd_pkg::FREQ_ALL_ONES)
            return res;
        rt = decode_tone(r.rxt);
        tt = decode_tone(r.txt);
        res.chan_on      = 1'b1;
        res.rx_hz        = 31'(bcd_weight(r.rx, 8) * 10);
        res.tx_hz        = 31'(bcd_weight(r.tx, 8) * 10);
        res.rx_ctcss     = rt.ctcss;
        res.tx_ctcss     = tt.ctcss;
        res.rx_dcs       = rt.dcs;
        res.tx_dcs       = tt.dcs;
        res.low_power    = ~r.opt[rcrd_pkg::OPT_HIGH_POWER];
        res.wide_band    = ~r.opt[rcrd_pkg::OPT_NARROW];
        res.scan_on      = ~r.opt[rcrd_pkg::OPT_NO_SCAN];
        res.busy_lockout = ~r.opt[rcrd_pkg::OPT_NO_BUSY_LOCK];
        res.scramble_on  = ~r.opt[rcrd_pkg::OPT_NO_SCRAMBLE];
        return res;
    endfunction

    // flags: {low_power, wide_band, scan_on, busy_lockout, scramble_on}
    function automatic chan_result_t mk_result(input bit on, input int unsigned rxhz, txhz,
                                               input int rxc, txc, rxd, txd,
                                               input logic [4:0] flags);
        chan_result_t res;
        res.chan_on  = on;
        res.rx_hz    = 31'(rxhz);
        res.tx_hz    = 31'(txhz);
        res.rx_ctcss = 13'(rxc);
        res.tx_ctcss = 13'(txc);
        res.rx_dcs   = 14'(rxd);
        res.tx_dcs   = 14'(txd);
        {res.low_power, res.wide_band, res.scan_on, res.busy_lockout, res.scramble_on} = flags;
        return res;
    endfunction

    task automatic add_row(input logic [31:0] rx, tx, input logic [15:0] rxt, txt,
                           input logic [4:0] opt, input bit typed, input chan_result_t res);
        chan_record_t r;
        r = {rx, tx, rxt, txt, opt};
        dir_records.push_back(r);
        dir_typed.push_back(typed);
        dir_results.push_back(res);
    endtask

    function automatic logic [31:0] rand_bcd(input int digits);
        logic [31:0] v;
        v = '0;
        for (int k = 0; k < digits; k++)
            v[4*k +: 4] = 4'($urandom_range(0, 9));
        return v;
    endfunction

    function automatic logic [31:0] rand_freq();
        case ($urandom_range(0, 19))
            0:       return 32'h0;
            1:       return rcrd_pkg::FREQ_ALL_ONES;
            2, 3:    return $urandom;
            default: return rand_bcd(8);
        endcase
    endfunction

    // leading nibble picks the tone class: 0-7 CTCSS, 8-B DCS, C-F inverted DCS
    function automatic logic [15:0] rand_tone();
        case ($urandom_range(0, 15))
            0:       return 16'h0000;
            1:       return rcrd_pkg::TONE_ALL_ONES;
            2, 3:    return 16'($urandom);
            default: return {4'($urandom_range(0, 15)), 12'(rand_bcd(3))};
        endcase
    endfunction

    task automatic send_record(input chan_record_t r, input bit typed, input chan_result_t res);
        int gap;
        gap = send_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        rx_freq_bcd  <= r.rx;
        tx_freq_bcd  <= r.tx;
        rx_tone_code <= r.rxt;
        tx_tone_code <= r.txt;
        option_bits  <= r.opt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_decodes.push_back(typed ? res : decode_record(r));
        records_sent++;
        if (r.rx == 32'h0 || r.rx == rcrd_pkg::FREQ_ALL_ONES)
            off_records++;
        if (r.rxt[15:12] >= 4'hC && r.rxt != rcrd_pkg::TONE_ALL_ONES)
            inverted_codes++;
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%t MISMATCH %s", $realtime, msg);
    endtask

    function automatic string show(input chan_result_t d);
        return $sformatf("on=%0d hz=%0d/%0d ctcss=%0d/%0d dcs=%0d/%0d flags=%b",
                         d.chan_on, d.rx_hz, d.tx_hz, d.rx_ctcss, d.tx_ctcss,
                         $signed(d.rx_dcs), $signed(d.tx_dcs),
                         {d.low_power, d.wide_band, d.scan_on, d.busy_lockout, d.scramble_on});
    endfunction

    task automatic check_decode(input chan_result_t got);
        chan_result_t want;
        string        bad;
        if (expected_decodes.size() == 0)
        begin
            note_mismatch({"unexpected item: ", show(got)});
            return;
        end
        want = expected_decodes.pop_front();
        decodes_checked++;
        bad = "";
        if (got.chan_on !== want.chan_on)           bad = {bad, " channel_on"};
        if (got.rx_hz !== want.rx_hz)               bad = {bad, " rx_hz"};
        if (got.tx_hz !== want.tx_hz)               bad = {bad, " tx_hz"};
        if (got.rx_ctcss !== want.rx_ctcss)         bad = {bad, " rx_ctcss"};
        if (got.tx_ctcss !== want.tx_ctcss)         bad = {bad, " tx_ctcss"};
        if (got.rx_dcs !== want.rx_dcs)             bad = {bad, " rx_dcs"};
        if (got.tx_dcs !== want.tx_dcs)             bad = {bad, " tx_dcs"};
        if (got.low_power !== want.low_power)       bad = {bad, " low_power"};
        if (got.wide_band !== want.wide_band)       bad = {bad, " wide_band"};
        if (got.scan_on !== want.scan_on)           bad = {bad, " scan_on"};
        if (got.busy_lockout !== want.busy_lockout) bad = {bad, " busy_lockout"};
        if (got.scramble_on !== want.scramble_on)   bad = {bad, " scramble_on"};
        if (bad != "")
            note_mismatch({"field(s)", bad, "\n    expected ", show(want),
                           "\n    actual   ", show(got)});
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_decode({channel_on, rx_hz, tx_hz, rx_ctcss, tx_ctcss, rx_dcs, tx_dcs,
                          low_power, wide_band, scan_on, busy_lockout, scramble_on});
    end

    // output back-pressure
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = recv_idle ? $urandom_range(0, 5) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // channel off, extremes, every tone class and each option bit
        add_row(32'h00000000, 32'h12345678, 16'h0885, 16'h8023, 5'h00, 1'b1, '0);
        add_row(32'hFFFFFFFF, 32'h99999999, 16'h1234, 16'hFFFF, 5'h1F, 1'b1, '0);
        add_row(32'hFFFFFFFF, 32'h00000000, 16'hC001, 16'h7999, 5'h00, 1'b1, '0);
        add_row(32'h99999999, 32'h00000001, 16'h0000, 16'hFFFF, 5'h00, 1'b1,
                mk_result(1, 999999990, 10, 0, 0, 0, 0, 5'b11111));
        add_row(32'hFFFFFFFE, 32'hFFFFFFFF, 16'h7999, 16'h8000, 5'h1F, 1'b1,
                mk_result(1, 1666666640, 1666666650, 7999, 0, 0, 0, 5'b00000));
        add_row(32'h00000001, 32'h00000000, 16'h8001, 16'hB999, 5'b01010, 1'b1,
                mk_result(1, 10, 0, 0, 0, 1, 3999, 5'b01110));
        add_row(32'h14652500, 32'h14652500, 16'hC000, 16'hC001, 5'b10101, 1'b1,
                mk_result(1, 146525000, 146525000, 0, 0, 0, -1, 5'b10001));
        add_row(32'h43912500, 32'h43912500, 16'hFFFE, 16'hFFFD, 5'h00, 1'b1,
                mk_result(1, 439125000, 439125000, 0, 0, -4664, -4663, 5'b11111));
        add_row(32'h14600000, 32'h14600000, 16'h0885, 16'h1000, 5'h00, 1'b1,
                mk_result(1, 146000000, 146000000, 885, 1000, 0, 0, 5'b11111));
        add_row(32'h0A0B0C0D, 32'hF0E0D0C0, 16'h7FFF, 16'hBFFF, 5'h01, 1'b0, '0);
        add_row(32'h80000000, 32'h00000000, 16'h0001, 16'hFFF0, 5'h02, 1'b0, '0);
        add_row(32'h00000010, 32'h44625000, 16'h9999, 16'hA000, 5'h04, 1'b0, '0);
        add_row(32'h15250000, 32'h15250000, 16'h0670, 16'h8754, 5'h08, 1'b0, '0);
        add_row(32'h46200000, 32'h46250000, 16'hC023, 16'h0885, 5'h10, 1'b0, '0);
        add_row(32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'hAAAA, 5'h15, 1'b0, '0);
        add_row(32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 16'h5555, 5'h0A, 1'b0, '0);
        add_row(32'h7FFFFFFF, 32'h80000000, 16'hFFFE, 16'h0000, 5'h1E, 1'b0, '0);

        for (int i = 0; i < dir_records.size(); i++)
            send_record(dir_records[i], dir_typed[i], dir_results[i]);

        // phases: both sides idle, neither, sender only, receiver only
        for (int n = 0; n < 700; n++)
        begin
            if (n % 100 == 0)
            begin
                phase = (n / 100) % 4;
                send_idle = (phase == 0 || phase == 2);
                recv_idle = (phase == 0 || phase == 3);
            end
            send_record({rand_freq(), rand_freq(), rand_tone(), rand_tone(),
                         5'($urandom_range(0, 31))}, 1'b0, '0);
        end
        in_valid <= 1'b0;

        wait (expected_decodes.size() == 0);
        repeat (20) @(posedge clk);

        $display("Sent %0d records (%0d channel off, %0d inverted receive codes)",
                 records_sent, off_records, inverted_codes);
        $display("%0d decodes checked, mismatches: %0d", decodes_checked, mismatch_count);
        if (mismatch_count == 0 && expected_decodes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
